// ----- design/ihi_pkg.sv -----
// package for the imu heading and integrator: widths, codes, cordic table
// no dependencies
package ihi_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned OneQ14      = 16384;
  localparam int unsigned FullTurnQ7  = 46080;
  localparam logic [15:0] TimeStepRst = 16'd655;

  // result kinds
  localparam logic [2:0] KIND_ACCEL  = 3'd0;
  localparam logic [2:0] KIND_CHANGE = 3'd1;
  localparam logic [2:0] KIND_ORIENT = 3'd2;
  localparam logic [2:0] KIND_VEL    = 3'd3;
  localparam logic [2:0] KIND_POS    = 3'd4;

  // shared divider command
  typedef struct packed {
    logic              start;
    logic signed [63:0] num;
    logic        [63:0] den;
  } div_cmd_t;

  // atan(2^-i) in degrees, Q.16
  function automatic logic [21:0] atan_deg(input logic [4:0] i);
    logic [21:0] r;
    begin
      case (i)
        5'd0: r = 22'd2949120;  5'd1: r = 22'd1740967;
        5'd2: r = 22'd919879;   5'd3: r = 22'd466945;
        5'd4: r = 22'd234379;   5'd5: r = 22'd117304;
        5'd6: r = 22'd58666;    5'd7: r = 22'd29335;
        5'd8: r = 22'd14668;    5'd9: r = 22'd7334;
        5'd10: r = 22'd3667;    5'd11: r = 22'd1833;
        5'd12: r = 22'd917;     5'd13: r = 22'd458;
        5'd14: r = 22'd229;     5'd15: r = 22'd115;
        5'd16: r = 22'd57;      5'd17: r = 22'd29;
        5'd18: r = 22'd14;      5'd19: r = 22'd7;
        5'd20: r = 22'd4;       5'd21: r = 22'd2;
        5'd22: r = 22'd1;       default: r = 22'd0;
      endcase
      return r;
    end
  endfunction

endpackage

// ----- design/ihi_sqrt.sv -----
// iterative integer square root of a 64-bit value, one result bit per cycle
// no dependencies
module ihi_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] val_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] rem_q, rem_d;
  logic [63:0] res_q, res_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [63:0] trial;

  // bit under test: 1 << (62 - 2*cnt)
  assign trial = res_q + (64'h4000_0000_0000_0000 >> {cnt_q[4:0], 1'b0});

  // one restoring step per cycle
  always_comb begin
    rem_d  = rem_q;
    res_d  = res_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = val_i;
      res_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        res_d = (res_q >> 1) + (64'h4000_0000_0000_0000 >> {cnt_q[4:0], 1'b0});
      end else begin
        res_d = res_q >> 1;
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[31:0];

endmodule

// ----- design/ihi_div.sv -----
// iterative rounded divider, half away from zero, one quotient bit per cycle
// depends on ihi_pkg for the command struct
module ihi_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ihi_pkg::div_cmd_t cmd_i,
  output logic              done_o,
  output logic signed [63:0] quo_o
);

  logic [63:0] a_w;
  logic [63:0] num_q, num_d;
  logic [63:0] den_q, den_d;
  logic [64:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic        neg_q, neg_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [64:0] sh;

  assign a_w = cmd_i.num[63] ? (64'd0 - cmd_i.num) : cmd_i.num;
  assign sh  = {rem_q[63:0], num_q[63]};

  // restoring long division of |n| + d/2 by d
  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (cmd_i.start) begin
      num_d  = a_w + (cmd_i.den >> 1);
      den_d  = cmd_i.den;
      rem_d  = '0;
      quo_d  = '0;
      neg_d  = cmd_i.num[63];
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = num_q << 1;
      if (sh >= {1'b0, den_q}) begin
        rem_d = sh - {1'b0, den_q};
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = sh;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quo_o  = (den_q == 64'd0) ? 64'sd0 :
                  (neg_q ? $signed(64'd0 - quo_q) : $signed(quo_q));

endmodule

// ----- design/imu_heading_and_integrator_top.sv -----
// Imu heading and integrator. One sample set is taken, then the block is busy with
// the work of the full path: three square roots, seven rounded quotients through
// the shared 64-bit divider, magnetometer products, a cordic run and nine
// integration steps through one shared multiplier. A zero acceleration sum skips
// the roots and quotients. Five result transfers follow, kinds 0 to 4, with last
// on the fifth; a new item is taken in the cycle after the fifth has gone.
// depends on ihi_pkg, ihi_sqrt, ihi_div
module imu_heading_and_integrator_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] accel_a_x_i,
  input  logic signed [15:0] accel_a_y_i,
  input  logic signed [15:0] accel_a_z_i,
  input  logic signed [15:0] gyro_x_i,
  input  logic signed [15:0] gyro_y_i,
  input  logic signed [15:0] gyro_z_i,
  input  logic signed [15:0] accel_b_x_i,
  input  logic signed [15:0] accel_b_y_i,
  input  logic signed [15:0] accel_b_z_i,
  input  logic signed [15:0] mag_x_i,
  input  logic signed [15:0] mag_y_i,
  input  logic signed [15:0] mag_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         kind_o,
  output logic signed [31:0] vec_x_o,
  output logic signed [31:0] vec_y_o,
  output logic signed [31:0] vec_z_o,
  output logic [15:0]        heading_o,
  output logic               last_o
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_NRM   = 5'd1;
  localparam logic [4:0] S_NRMW  = 5'd2;
  localparam logic [4:0] S_UDIV  = 5'd3;
  localparam logic [4:0] S_UDIVW = 5'd4;
  localparam logic [4:0] S_TRIG  = 5'd5;
  localparam logic [4:0] S_HSQW  = 5'd6;
  localparam logic [4:0] S_RSQW  = 5'd7;
  localparam logic [4:0] S_TDIV  = 5'd8;
  localparam logic [4:0] S_TDIVW = 5'd9;
  localparam logic [4:0] S_MAG   = 5'd10;
  localparam logic [4:0] S_CORD  = 5'd11;
  localparam logic [4:0] S_HEAD  = 5'd12;
  localparam logic [4:0] S_INT   = 5'd13;
  localparam logic [4:0] S_OUT   = 5'd14;
  localparam logic [4:0] S_MAGP  = 5'd15;

  logic [4:0]  state_q;
  logic [15:0] tstep_q;

  logic signed [16:0] s_q [3];
  logic signed [15:0] g_q [3];
  logic signed [15:0] m_q [3];
  logic signed [15:0] u_q [3];
  logic signed [15:0] cp_q, sp_q, cr_q, sr_q;
  logic [31:0]        mag_q, hh_q, rr_q;
  logic [1:0]         idx_q;
  logic [1:0]         sub_q;
  logic signed [15:0] prate_q [3];
  logic signed [15:0] pacc_q  [3];
  logic signed [31:0] ori_q [3];
  logic signed [31:0] vel_q [3];
  logic signed [31:0] pos_q [3];
  logic signed [31:0] chg_q [3];
  logic signed [63:0] cx_q, cy_q;
  logic signed [31:0] cz_q;
  logic [4:0]         ci_q;
  logic               hzero_q;
  logic [15:0]        head_q;
  logic [2:0]         kind_q;
  logic signed [32:0] mxa_q;
  logic signed [31:0] m0sr_q, m2sr_q, m1cr_q;

  // shared units
  logic        sq_start;
  logic [63:0] sq_val;
  logic        sq_done;
  logic [31:0] sq_root;
  ihi_pkg::div_cmd_t dcmd;
  logic        dv_done;
  logic signed [63:0] dv_quo;

  ihi_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .val_i(sq_val),
    .done_o(sq_done), .root_o(sq_root)
  );
  ihi_div u_div (
    .clk_i, .rst_ni, .cmd_i(dcmd), .done_o(dv_done), .quo_o(dv_quo)
  );

  // small helpers
  function automatic logic signed [15:0] clamp_u(input logic signed [63:0] v);
    if (v > 64'sd16384) return 16'sd16384;
    if (v < -64'sd16384) return -16'sd16384;
    return v[15:0];
  endfunction
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // squared-magnitude terms
  logic [63:0] q_w, tq_w, sqq_w;
  assign q_w = 64'($signed(s_q[0]) * $signed(s_q[0])) + 64'($signed(s_q[1]) * $signed(s_q[1]))
             + 64'($signed(s_q[2]) * $signed(s_q[2]));
  assign tq_w  = 64'(u_q[1] * u_q[1]) + 64'(u_q[2] * u_q[2]);
  assign sqq_w = tq_w + 64'(u_q[0] * u_q[0]);

  // integration products, one axis per step via one multiplier
  logic signed [33:0] mul_a;
  logic signed [50:0] prod;
  assign prod = mul_a * $signed({1'b0, tstep_q});

  always_comb begin
    case (sub_q)
      2'd0:    mul_a = 34'(g_q[idx_q]) + 34'(prate_q[idx_q]);
      2'd1:    mul_a = 34'(u_q[idx_q]) + 34'(pacc_q[idx_q]);
      default: mul_a = 34'(vel_q[idx_q]);
    endcase
  end

  // magnetometer products of sensor and trig terms, registered in S_MAGP
  logic signed [31:0] p_m0cp, p_m2sp, p_m0sr, p_m2sr, p_m1cr;
  assign p_m0cp = 32'(m_q[0]) * 32'(cp_q);
  assign p_m2sp = 32'(m_q[2]) * 32'(sp_q);
  assign p_m0sr = 32'(m_q[0]) * 32'(sr_q);
  assign p_m2sr = 32'(m_q[2]) * 32'(sr_q);
  assign p_m1cr = 32'(m_q[1]) * 32'(cr_q);

  // magnetometer compensation terms, scale 2^28, from the S_MAGP registers in S_MAG
  logic signed [47:0] p_y0, p_y2;
  logic signed [63:0] magx_w, magy_w;
  assign p_y0   = 48'(m0sr_q) * 48'(sp_q);
  assign p_y2   = 48'(m2sr_q) * 48'(cp_q);
  assign magx_w = 64'(mxa_q) <<< 14;
  assign magy_w = 64'(p_y0) + (64'(m1cr_q) <<< 14) - 64'(p_y2);

  // cordic step
  logic signed [63:0] dx_w, dy_w;
  assign dx_w = cy_q >>> ci_q;
  assign dy_w = cx_q >>> ci_q;
  logic signed [31:0] hq_w;
  assign hq_w = (cz_q + 32'sd256) >>> 9;

  logic in_acc, out_acc;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_valid_o = (state_q == S_OUT);
  assign out_acc    = out_valid_o & ~out_stall_i;

  // command drives for shared units
  always_comb begin
    sq_start   = 1'b0;
    sq_val     = '0;
    dcmd.start = 1'b0;
    dcmd.num   = '0;
    dcmd.den   = '0;
    unique case (state_q)
      S_NRM: begin
        sq_start = (q_w != 64'd0);
        sq_val   = q_w << 28;
      end
      S_UDIV: begin
        dcmd.start = 1'b1;
        dcmd.num   = 64'(s_q[idx_q]) <<< 28;
        dcmd.den   = {32'd0, mag_q};
      end
      S_TRIG: begin
        sq_start = (tq_w != 64'd0);
        sq_val   = tq_w << 28;
      end
      S_HSQW: begin
        sq_start = (sq_done | (tq_w == 64'd0)) & (sqq_w != 64'd0);
        sq_val   = sqq_w << 28;
      end
      S_TDIV: begin
        dcmd.start = 1'b1;
        unique case (idx_q)
          2'd0: begin dcmd.num = 64'({hh_q}) * 64'sd16384; dcmd.den = {32'd0, rr_q}; end
          2'd1: begin dcmd.num = -(64'(u_q[0]) <<< 28); dcmd.den = {32'd0, rr_q}; end
          2'd2: begin dcmd.num = 64'(u_q[1]) <<< 28; dcmd.den = {32'd0, hh_q}; end
          default: begin dcmd.num = 64'(u_q[2]) <<< 28; dcmd.den = {32'd0, hh_q}; end
        endcase
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tstep_q <= ihi_pkg::TimeStepRst;
      idx_q   <= '0;
      sub_q   <= '0;
      kind_q  <= '0;
      for (int i = 0; i < 3; i++) begin
        prate_q[i] <= '0; pacc_q[i] <= '0;
        ori_q[i] <= '0; vel_q[i] <= '0; pos_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) tstep_q <= cfg_wdata_i;
      unique case (state_q)
        S_IDLE: if (in_acc) begin
          s_q[0] <= 17'(accel_a_x_i) + 17'(accel_b_x_i);
          s_q[1] <= 17'(accel_a_y_i) + 17'(accel_b_y_i);
          s_q[2] <= 17'(accel_a_z_i) + 17'(accel_b_z_i);
          g_q[0] <= gyro_x_i; g_q[1] <= gyro_y_i; g_q[2] <= gyro_z_i;
          m_q[0] <= mag_x_i;  m_q[1] <= mag_y_i;  m_q[2] <= mag_z_i;
          state_q <= S_NRM;
        end
        S_NRM: begin
          idx_q <= '0;
          if (q_w == 64'd0) begin
            for (int i = 0; i < 3; i++) u_q[i] <= '0;
            state_q <= S_TRIG;
          end else begin
            state_q <= S_NRMW;
          end
        end
        S_NRMW: if (sq_done) begin
          mag_q   <= sq_root;
          state_q <= S_UDIV;
        end
        S_UDIV: state_q <= S_UDIVW;
        S_UDIVW: if (dv_done) begin
          u_q[idx_q] <= clamp_u(dv_quo);
          if (idx_q == 2'd2) begin
            idx_q   <= '0;
            state_q <= S_TRIG;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= S_UDIV;
          end
        end
        S_TRIG: begin
          hh_q    <= '0;
          state_q <= S_HSQW;
        end
        S_HSQW: if (sq_done | (tq_w == 64'd0)) begin
          if (tq_w != 64'd0) hh_q <= sq_root;
          state_q <= (sqq_w == 64'd0) ? S_TDIV : S_RSQW;
          idx_q   <= (sqq_w == 64'd0) ? 2'd2 : 2'd0;
          if (sqq_w == 64'd0) begin
            cp_q <= 16'sd16384; sp_q <= '0;
            if (tq_w == 64'd0) begin
              cr_q <= 16'sd16384; sr_q <= '0; state_q <= S_MAGP;
            end
          end
        end
        S_RSQW: if (sq_done) begin
          rr_q    <= sq_root;
          state_q <= S_TDIV;
        end
        S_TDIV: state_q <= S_TDIVW;
        S_TDIVW: if (dv_done) begin
          unique case (idx_q)
            2'd0: cp_q <= clamp_u(dv_quo);
            2'd1: sp_q <= clamp_u(dv_quo);
            2'd2: sr_q <= clamp_u(dv_quo);
            default: cr_q <= clamp_u(dv_quo);
          endcase
          if (idx_q == 2'd3) begin
            state_q <= S_MAGP;
          end else if (idx_q == 2'd1 && tq_w == 64'd0) begin
            cr_q <= 16'sd16384; sr_q <= '0; state_q <= S_MAGP;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= S_TDIV;
          end
        end
        S_MAGP: begin
          mxa_q   <= 33'(p_m0cp) + 33'(p_m2sp);
          m0sr_q  <= p_m0sr;
          m2sr_q  <= p_m2sr;
          m1cr_q  <= p_m1cr;
          state_q <= S_MAG;
        end
        S_MAG: begin
          hzero_q <= (magx_w == 64'sd0) && (magy_w == 64'sd0);
          ci_q    <= '0;
          if (magx_w < 0) begin
            cx_q <= -magx_w; cy_q <= magy_w; cz_q <= 32'sd11796480;
          end else begin
            cx_q <= magx_w;  cy_q <= -magy_w; cz_q <= '0;
          end
          state_q <= S_CORD;
        end
        S_CORD: begin
          if (cy_q > 0) begin
            cx_q <= cx_q + dx_w; cy_q <= cy_q - dy_w;
            cz_q <= cz_q + $signed({10'd0, ihi_pkg::atan_deg(ci_q)});
          end else begin
            cx_q <= cx_q - dx_w; cy_q <= cy_q + dy_w;
            cz_q <= cz_q - $signed({10'd0, ihi_pkg::atan_deg(ci_q)});
          end
          ci_q <= ci_q + 5'd1;
          if (ci_q == 5'(ihi_pkg::CordicSteps - 1)) state_q <= S_HEAD;
        end
        S_HEAD: begin
          if (hzero_q) head_q <= '0;
          else if (hq_w < 0) head_q <= 16'(hq_w + 32'sd46080);
          else if (hq_w >= 32'sd46080) head_q <= 16'(hq_w - 32'sd46080);
          else head_q <= hq_w[15:0];
          idx_q   <= '0;
          sub_q   <= '0;
          state_q <= S_INT;
        end
        S_INT: begin
          unique case (sub_q)
            2'd0: begin
              chg_q[idx_q]   <= 32'((64'(prod) + 64'sd4096) >>> 13);
              ori_q[idx_q]   <= sat32(64'(ori_q[idx_q]) + ((64'(prod) + 64'sd4096) >>> 13));
              prate_q[idx_q] <= g_q[idx_q];
              sub_q <= 2'd1;
            end
            2'd1: begin
              vel_q[idx_q]  <= sat32(64'(vel_q[idx_q]) + ((64'(prod) + 64'sd16384) >>> 15));
              pacc_q[idx_q] <= u_q[idx_q];
              sub_q <= 2'd2;
            end
            default: begin
              pos_q[idx_q] <= sat32(64'(pos_q[idx_q]) + ((64'(prod) + 64'sd32768) >>> 16));
              sub_q <= 2'd0;
              if (idx_q == 2'd2) begin
                kind_q  <= ihi_pkg::KIND_ACCEL;
                state_q <= S_OUT;
              end else begin
                idx_q <= idx_q + 2'd1;
              end
            end
          endcase
        end
        S_OUT: if (out_acc) begin
          if (kind_q == ihi_pkg::KIND_POS) state_q <= S_IDLE;
          else kind_q <= kind_q + 3'd1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result selection
  always_comb begin
    case (kind_q)
      ihi_pkg::KIND_ACCEL: begin
        vec_x_o = 32'(u_q[0]); vec_y_o = 32'(u_q[1]); vec_z_o = 32'(u_q[2]);
      end
      ihi_pkg::KIND_CHANGE: begin
        vec_x_o = chg_q[0]; vec_y_o = chg_q[1]; vec_z_o = chg_q[2];
      end
      ihi_pkg::KIND_ORIENT: begin
        vec_x_o = ori_q[0]; vec_y_o = ori_q[1]; vec_z_o = ori_q[2];
      end
      ihi_pkg::KIND_VEL: begin
        vec_x_o = vel_q[0]; vec_y_o = vel_q[1]; vec_z_o = vel_q[2];
      end
      default: begin
        vec_x_o = pos_q[0]; vec_y_o = pos_q[1]; vec_z_o = pos_q[2];
      end
    endcase
  end

  assign kind_o    = kind_q;
  assign heading_o = head_q;
  assign last_o    = (kind_q == ihi_pkg::KIND_POS);

endmodule
